/* design/scli_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command line interpreter package
// Shared constants, codes, sequencer types and character helpers.
// ----------------------------------------------------------------------------
package scli_pkg;

  // Default line buffer size, the terminator slot included
  localparam int LINE_CAPACITY_DEF = 64;

  // Blink period after reset, in milliseconds
  localparam logic [31:0] BLINK_RESET = 32'd500;

  // Line terminators
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Response codes
  localparam logic [2:0] RESP_NONE     = 3'd0;
  localparam logic [2:0] RESP_LED_ON   = 3'd1;
  localparam logic [2:0] RESP_LED_OFF  = 3'd2;
  localparam logic [2:0] RESP_STAT_ON  = 3'd3;
  localparam logic [2:0] RESP_STAT_OFF = 3'd4;
  localparam logic [2:0] RESP_DELAY    = 3'd5;
  localparam logic [2:0] RESP_UNKNOWN  = 3'd6;

  // Command texts, padded with zero bytes to eight characters
  typedef logic [7:0] text_t [8];

  localparam text_t TXT_LED_ON  = '{"L", "E", "D", " ", "O", "N", 8'h00, 8'h00};
  localparam text_t TXT_LED_OFF = '{"L", "E", "D", " ", "O", "F", "F", 8'h00};
  localparam text_t TXT_STATUS  = '{"S", "T", "A", "T", "U", "S", 8'h00, 8'h00};
  localparam text_t TXT_DELAY   = '{"D", "E", "L", "A", "Y", 8'h00, 8'h00, 8'h00};

  localparam int LEN_LED_ON  = 6;
  localparam int LEN_LED_OFF = 7;
  localparam int LEN_STATUS  = 6;
  localparam int LEN_DELAY   = 5;

  // Main sequencer
  typedef enum logic [1:0] {
    S_IDLE,
    S_ECHO,
    S_SCAN,
    S_DONE
  } state_t;

  // DELAY argument parser
  typedef enum logic [2:0] {
    P_PREFIX,
    P_SPACE,
    P_FIRST,
    P_NUM,
    P_TAIL,
    P_FAIL
  } phase_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == " ") || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

endpackage

/* design/scli_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interpreter input channel
// Valid/ready channel carrying one received byte or one millisecond tick.
// ----------------------------------------------------------------------------
interface scli_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

/* design/scli_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interpreter result channel
// Valid/ready channel carrying one transmit byte, response and status.
// ----------------------------------------------------------------------------
interface scli_out_if;
  logic        valid;
  logic        ready;
  logic        has_tx;
  logic [7:0]  tx_byte;
  logic [2:0]  response;
  logic [31:0] delay_value;
  logic        led;
  logic        last;

  modport source (output valid, output has_tx, output tx_byte, output response,
                  output delay_value, output led, output last, input ready);
  modport sink   (input valid, input has_tx, input tx_byte, input response,
                  input delay_value, input led, input last, output ready);
endinterface

/* design/scli_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module scli_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 63,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/serial_command_line_interpreter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command line interpreter
// Echoes received bytes, buffers a line and decodes LED, STATUS and DELAY
// commands; millisecond ticks drive the blinking LED.
// ----------------------------------------------------------------------------
// A tick or an ordinary byte gives one result in the cycle after it is taken,
// and the block takes its next request in the cycle after that result is
// taken. A CR or LF byte gives two results: the echo, then a line feed
// carrying the response. After the echo is taken the stored line is read
// back from the line RAM one character per cycle up to the first zero byte
// or the end of the stored line (at most LINE_CAPACITY-1 characters), and
// the line feed result follows that read-back. The block takes no request
// until the last result of the current one has been taken. delay_value and
// led show the live blink period and LED level, so the echo of a line end
// shows them before the command and the line feed after it.
// ----------------------------------------------------------------------------
module serial_command_line_interpreter #(
  parameter int LINE_CAPACITY = scli_pkg::LINE_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  scli_in_if.sink     cmd,
  scli_out_if.source  result
);
  import scli_pkg::*;

  localparam int DEPTH  = LINE_CAPACITY - 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LEN_W  = $clog2(LINE_CAPACITY);

  // Control state
  state_t            state;
  state_t            state_next;
  logic [LEN_W-1:0]  line_length;
  logic              led_level;
  logic [31:0]       blink_period;
  logic [31:0]       elapsed_ms;

  // Result payload
  logic              has_tx;
  logic [7:0]        tx_byte;
  logic [2:0]        response;

  // Scan state
  logic [LEN_W-1:0]  idx;
  phase_t            phase;
  phase_t            phase_next;
  logic              m_on;
  logic              m_off;
  logic              m_stat;
  logic [31:0]       acc;
  logic [31:0]       acc_next;
  logic              neg;
  logic              neg_next;
  logic              sat;
  logic              sat_next;

  // Handshake and RAM signals
  logic              cmd_fire;
  logic              out_fire;
  logic              is_eol;
  logic              store_ok;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic [LEN_W-1:0]  idx_inc;
  logic              scan_end;

  // Character and finish helpers
  logic [7:0]        ch;
  logic [35:0]       prod;
  logic              take_digit;
  logic              hit_on;
  logic              hit_off;
  logic              hit_stat;
  logic              delay_ok;
  logic [2:0]        resp_code;
  logic [31:0]       delay_new;
  logic [31:0]       elapsed_inc;

  assign cmd_fire    = cmd.valid && cmd.ready;
  assign out_fire    = result.valid && result.ready;
  assign is_eol      = (cmd.rx_byte == CHAR_CR) || (cmd.rx_byte == CHAR_LF);
  assign store_ok    = line_length < LEN_W'(DEPTH);
  assign idx_inc     = idx + 1'b1;
  assign ch          = ram_rdata;
  assign scan_end    = (idx == line_length) || (ch == 8'h00);
  assign elapsed_inc = elapsed_ms + 32'd1;

  // Line store
  scli_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (line_length[ADDR_W-1:0]),
    .wr_data (cmd.rx_byte),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          state_next = (!cmd.kind && is_eol) ? S_ECHO : S_DONE;
        end
      end
      S_ECHO: begin
        if (result.ready) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (result.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    cmd.ready    = 1'b0;
    result.valid = 1'b0;
    result.last  = 1'b0;
    ram_we       = 1'b0;
    ram_raddr    = '0;
    unique case (state)
      S_IDLE: begin
        cmd.ready = 1'b1;
        ram_we    = cmd.valid && !cmd.kind && !is_eol && store_ok;
      end
      S_ECHO: begin
        result.valid = 1'b1;
      end
      S_SCAN: begin
        ram_raddr = idx_inc[ADDR_W-1:0];
      end
      S_DONE: begin
        result.valid = 1'b1;
        result.last  = 1'b1;
      end
      default: begin
        cmd.ready = 1'b0;
      end
    endcase
  end

  assign result.has_tx      = has_tx;
  assign result.tx_byte     = tx_byte;
  assign result.response    = response;
  assign result.delay_value = blink_period;
  assign result.led         = led_level;

  // Step the DELAY parser by one character
  assign prod       = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {32'b0, ch[3:0] - 4'd0};
  assign take_digit = is_digit(ch) && (phase == P_SPACE || phase == P_FIRST ||
                                       phase == P_NUM);

  always_comb begin
    phase_next = phase;
    neg_next   = neg;
    acc_next   = acc;
    sat_next   = sat;
    unique case (phase) inside
      P_PREFIX: begin
        if (ch != TXT_DELAY[idx[2:0]]) begin
          phase_next = P_FAIL;
        end else if (idx == LEN_W'(LEN_DELAY - 1)) begin
          phase_next = P_SPACE;
        end
      end
      P_SPACE: begin
        if (is_space(ch)) begin
          phase_next = P_SPACE;
        end else if (ch == "+" || ch == "-") begin
          neg_next   = (ch == "-");
          phase_next = P_FIRST;
        end else if (is_digit(ch)) begin
          phase_next = P_NUM;
        end else begin
          phase_next = P_FAIL;
        end
      end
      P_FIRST: begin
        phase_next = is_digit(ch) ? P_NUM : P_FAIL;
      end
      P_NUM: begin
        if (!is_digit(ch)) begin
          phase_next = P_TAIL;
        end
      end
      P_TAIL, P_FAIL: begin
        phase_next = phase;
      end
      default: phase_next = P_FAIL;
    endcase
    // Accumulate the digit unless already saturated
    if (take_digit && !sat) begin
      acc_next = prod[31:0];
      sat_next = |prod[35:32];
    end
  end

  // Decide the response at line end
  assign hit_on   = m_on   && (idx == LEN_W'(LEN_LED_ON));
  assign hit_off  = m_off  && (idx == LEN_W'(LEN_LED_OFF));
  assign hit_stat = m_stat && (idx == LEN_W'(LEN_STATUS));
  assign delay_ok = (phase == P_NUM) || (phase == P_TAIL);
  assign delay_new = sat ? 32'hFFFF_FFFF : (neg ? (32'd0 - acc) : acc);

  always_comb begin
    if (hit_on) begin
      resp_code = RESP_LED_ON;
    end else if (hit_off) begin
      resp_code = RESP_LED_OFF;
    end else if (hit_stat) begin
      resp_code = led_level ? RESP_STAT_ON : RESP_STAT_OFF;
    end else if (delay_ok) begin
      resp_code = RESP_DELAY;
    end else if (idx != '0) begin
      resp_code = RESP_UNKNOWN;
    end else begin
      resp_code = RESP_NONE;
    end
  end

  // Update line length, LED, blink period and tick count
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length  <= '0;
      led_level    <= 1'b0;
      blink_period <= BLINK_RESET;
      elapsed_ms   <= '0;
    end else begin
      if (state == S_IDLE && cmd_fire) begin
        if (cmd.kind) begin
          if (elapsed_inc >= blink_period) begin
            led_level  <= ~led_level;
            elapsed_ms <= '0;
          end else begin
            elapsed_ms <= elapsed_inc;
          end
        end else if (!is_eol && store_ok) begin
          line_length <= line_length + 1'b1;
        end
      end
      if (state == S_SCAN && scan_end) begin
        line_length <= '0;
        if (hit_on) begin
          led_level <= 1'b1;
        end else if (hit_off) begin
          led_level <= 1'b0;
        end else if (!hit_stat && delay_ok) begin
          blink_period <= delay_new;
        end
      end
    end
  end

  // Load result payload and scan registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_fire) begin
      has_tx   <= !cmd.kind;
      tx_byte  <= cmd.kind ? 8'h00 : cmd.rx_byte;
      response <= RESP_NONE;
      idx      <= '0;
      phase    <= P_PREFIX;
      m_on     <= 1'b1;
      m_off    <= 1'b1;
      m_stat   <= 1'b1;
      acc      <= '0;
      neg      <= 1'b0;
      sat      <= 1'b0;
    end
    if (state == S_SCAN) begin
      if (scan_end) begin
        has_tx   <= 1'b1;
        tx_byte  <= CHAR_LF;
        response <= resp_code;
      end else begin
        idx    <= idx_inc;
        phase  <= phase_next;
        acc    <= acc_next;
        neg    <= neg_next;
        sat    <= sat_next;
        m_on   <= m_on && (idx < LEN_W'(LEN_LED_ON)) && (ch == TXT_LED_ON[idx[2:0]]);
        m_off  <= m_off && (idx < LEN_W'(LEN_LED_OFF)) && (ch == TXT_LED_OFF[idx[2:0]]);
        m_stat <= m_stat && (idx < LEN_W'(LEN_STATUS)) && (ch == TXT_STATUS[idx[2:0]]);
      end
    end
  end

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.ready && result.valid))
    else $error("request taken while a result is pending");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    line_length <= LEN_W'(DEPTH))
    else $error("line length beyond buffer depth");

  a_eol_echo: assert property (@(posedge clk) disable iff (rst)
    cmd_fire && !cmd.kind && is_eol |=> state == S_ECHO && result.has_tx && !result.last)
    else $error("line end not followed by its echo");

  a_echo_scan: assert property (@(posedge clk) disable iff (rst)
    out_fire && state == S_ECHO |=> state == S_SCAN && idx == '0)
    else $error("echo taken without starting the line scan");

endmodule

/* test/scli_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interpreter result checker
// Watches both channels of the command line interpreter, predicts the
// results of every accepted request from its own model of the line buffer,
// LED and blink timer, and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module scli_checker #(
  parameter int LINE_CAPACITY = scli_pkg::LINE_CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  scli_in_if   cmd,
  scli_out_if  result,
  output int   fail_count,
  output int   pending,
  output int   result_count,
  output int   line_count
);
  import scli_pkg::*;

  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic        has_tx;
    logic [7:0]  tx_byte;
    logic [2:0]  response;
    logic [31:0] delay_value;
    logic        led;
    logic        last;
  } result_t;

  result_t     expected_q[$];

  // Predicted block state
  logic [7:0]  line_buf [LINE_CAPACITY-1];
  int          line_len;
  logic        led_lvl;
  logic [31:0] period;
  logic [31:0] elapsed_ms;

  // Queue one predicted result, showing the live period and LED level
  function automatic void push_result(logic has, logic [7:0] tx, logic [2:0] resp,
                                      logic fin);
    result_t r;
    r.has_tx      = has;
    r.tx_byte     = tx;
    r.response    = resp;
    r.delay_value = period;
    r.led         = led_lvl;
    r.last        = fin;
    expected_q.push_back(r);
  endfunction

  // True when the first n stored characters begin with the given text
  function automatic logic starts_with(int n, string s);
    if (n < s.len()) return 1'b0;
    for (int i = 0; i < s.len(); i++) begin
      if (line_buf[i] != s[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Decode the stored line and apply the command to the predicted state
  function automatic logic [2:0] decode_line();
    int          n;
    int          i;
    logic        neg;
    logic        sat;
    logic [63:0] acc;
    n = 0;
    while (n < line_len && line_buf[n] != 8'h00) n++;
    if (n == 6 && starts_with(n, "LED ON")) begin
      led_lvl = 1'b1;
      return RESP_LED_ON;
    end
    if (n == 7 && starts_with(n, "LED OFF")) begin
      led_lvl = 1'b0;
      return RESP_LED_OFF;
    end
    if (n == 6 && starts_with(n, "STATUS")) return led_lvl ? RESP_STAT_ON : RESP_STAT_OFF;
    if (starts_with(n, "DELAY")) begin
      i   = 5;
      neg = 1'b0;
      sat = 1'b0;
      acc = '0;
      // skip blanks, then take an optional sign
      while (i < n && (line_buf[i] == " " || (line_buf[i] >= 8'd9 && line_buf[i] <= 8'd13)))
        i++;
      if (i < n && (line_buf[i] == "+" || line_buf[i] == "-")) begin
        neg = (line_buf[i] == "-");
        i++;
      end
      if (i < n && line_buf[i] >= "0" && line_buf[i] <= "9") begin
        // accumulate digits, saturating once the value leaves 32 bits
        while (i < n && line_buf[i] >= "0" && line_buf[i] <= "9") begin
          if (!sat) begin
            acc = acc * 10 + 64'(line_buf[i] - "0");
            if (acc > 64'hFFFF_FFFF) sat = 1'b1;
          end
          i++;
        end
        if (sat)      period = '1;
        else if (neg) period = -acc[31:0];
        else          period = acc[31:0];
        return RESP_DELAY;
      end
    end
    return (n > 0) ? RESP_UNKNOWN : RESP_NONE;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t    want;
    logic [7:0] c;
    logic [2:0] resp;
    if (rst) begin
      line_len   = 0;
      led_lvl    = 1'b0;
      period     = BLINK_RESET;
      elapsed_ms = '0;
      expected_q.delete();
    end else begin
      // Predict the results of an accepted request
      if (cmd.valid && cmd.ready) begin
        c = cmd.rx_byte;
        if (cmd.kind == KIND_TICK) begin
          elapsed_ms = elapsed_ms + 1;
          if (elapsed_ms >= period) begin
            led_lvl    = ~led_lvl;
            elapsed_ms = '0;
          end
          push_result(1'b0, 8'h00, RESP_NONE, 1'b1);
        end else if (c == CHAR_CR || c == CHAR_LF) begin
          push_result(1'b1, c, RESP_NONE, 1'b0);
          resp     = decode_line();
          line_len = 0;
          line_count++;
          push_result(1'b1, CHAR_LF, resp, 1'b1);
        end else begin
          // drop bytes once the line is full
          if (line_len < LINE_CAPACITY - 1) begin
            line_buf[line_len] = c;
            line_len++;
          end
          push_result(1'b1, c, RESP_NONE, 1'b1);
        end
      end

      // Compare an accepted result with the oldest prediction
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: tx_byte %0h, response %0d", result.tx_byte,
                 result.response);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          compare_field("has_tx", want.has_tx, result.has_tx);
          compare_field("tx_byte", want.tx_byte, result.tx_byte);
          compare_field("response", want.response, result.response);
          compare_field("delay_value", want.delay_value, result.delay_value);
          compare_field("led", want.led, result.led);
          compare_field("last", want.last, result.last);
          result_count++;
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

/* test/tb_serial_command_line_interpreter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command line interpreter testbench
// Sends command lines, malformed text, long lines and millisecond ticks
// through four handshake phases with random idling, a long result stall
// and drain pauses; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_serial_command_line_interpreter;
  import scli_pkg::*;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_TICK   = 1'b1;
  localparam int   HOLD_CYCLES = 400;
  localparam int   STALL_LIMIT = 3000;
  localparam int   TAIL_CYCLES = 100;
  localparam int   PHASE_ITEMS = 195;

  logic clk;
  logic rst;

  scli_in_if  cmd_if ();
  scli_out_if res_if ();

  int   fail_count;
  int   pending;
  int   result_count;
  int   line_count;
  int   items_sent   = 0;
  int   idle_pct     = 0;
  int   stall_pct    = 0;
  logic hold_go      = 1'b0;
  logic hold_done    = 1'b0;
  int   quiet_cycles = 0;

  logic [7:0] line_q[$];

  serial_command_line_interpreter i_dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_if),
    .result (res_if)
  );

  scli_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd_if),
    .result       (res_if),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count),
    .line_count   (line_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, plus one long hold-off when requested
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no request or result moved for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request after a random gap and hold it until accepted
  task automatic send_req(logic k, logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.kind    <= k;
    cmd_if.rx_byte <= b;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_req(KIND_BYTE, s[i]);
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  // Append random bytes, steering clear of the line terminators
  function automatic void add_noise(int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(255));
      if (b == CHAR_CR || b == CHAR_LF) b = b ^ 8'h80;
      line_q.push_back(b);
    end
  endfunction

  function automatic void add_digits(int n);
    repeat (n) line_q.push_back("0" + 8'($urandom_range(9)));
  endfunction

  // Build a DELAY line with random blanks, sign, digits and trailing text
  function automatic void add_delay();
    int r;
    add_text("DELAY");
    repeat ($urandom_range(3)) begin
      case ($urandom_range(3))
        0:       line_q.push_back(8'h20);
        1:       line_q.push_back(8'h09);
        2:       line_q.push_back(8'h0B);
        default: line_q.push_back(8'h0C);
      endcase
    end
    r = $urandom_range(5);
    if (r == 0)      line_q.push_back("+");
    else if (r == 1) line_q.push_back("-");
    r = $urandom_range(99);
    if (r < 75)      add_digits($urandom_range(1, 2));
    else if (r < 85) ;
    else if (r < 92) add_digits($urandom_range(9, 12));
    else             add_text($urandom_range(1) ? "4294967295" : "4294967296");
    if ($urandom_range(99) < 25) add_noise($urandom_range(1, 4));
  endfunction

  // Send the built line with the odd tick mixed in, then a terminator
  task automatic flush_line();
    foreach (line_q[i]) begin
      if ($urandom_range(99) < 6) send_req(KIND_TICK, 8'($urandom_range(255)));
      send_req(KIND_BYTE, line_q[i]);
    end
    send_req(KIND_BYTE, $urandom_range(1) ? CHAR_CR : CHAR_LF);
    line_q.delete();
  endtask

  // Generate one random line or a burst of ticks
  task automatic gen_random_line();
    int    r;
    int    k;
    string cmd_txt[3];
    cmd_txt = '{"LED ON", "LED OFF", "STATUS"};
    r = $urandom_range(99);
    if (r < 15) begin
      add_text(cmd_txt[$urandom_range(2)]);
    end else if (r < 40) begin
      add_delay();
    end else if (r < 50) begin
      // near miss: flip a bit, append a byte or truncate
      add_text(cmd_txt[$urandom_range(2)]);
      k = $urandom_range(2);
      if (k == 0) begin
        k = $urandom_range(line_q.size() - 1);
        line_q[k] = line_q[k] ^ (8'h01 << $urandom_range(7));
      end else if (k == 1) begin
        add_noise(1);
      end else begin
        void'(line_q.pop_back());
      end
    end else if (r < 55) begin
      // empty line
    end else if (r < 58) begin
      add_noise(60 + $urandom_range(15));
    end else if (r < 65) begin
      // command cut short by a zero byte
      if ($urandom_range(1)) add_text(cmd_txt[$urandom_range(2)]);
      else add_delay();
      line_q.push_back(8'h00);
      add_noise($urandom_range(5));
    end else if (r < 80) begin
      add_noise($urandom_range(1, 10));
    end else begin
      repeat ($urandom_range(1, 30)) send_req(KIND_TICK, 8'($urandom_range(255)));
      return;
    end
    flush_line();
  endtask

  // Hold the sender until every predicted result has arrived
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int ph;
    rst            <= 1'b1;
    cmd_if.valid   <= 1'b0;
    cmd_if.kind    <= KIND_BYTE;
    cmd_if.rx_byte <= 8'h00;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: LED ON, STATUS and DELAY 0, zero period ticks, empty line
    send_text("LED ON");
    send_req(KIND_BYTE, CHAR_CR);
    send_text("STATUS");
    send_req(KIND_BYTE, CHAR_LF);
    send_text("DELAY 0");
    send_req(KIND_BYTE, CHAR_CR);
    send_req(KIND_TICK, 8'h00);
    send_req(KIND_TICK, 8'hFF);
    send_req(KIND_BYTE, CHAR_LF);
    cmd_if.valid <= 1'b0;
    wait_drained();

    // Random phases with different idling on each side
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
          hold_go   <= 1'b1;
        end
        1: begin
          idle_pct = 49;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 49;
        end
        default: begin
          idle_pct = 30;
          stall_pct <= 30;
        end
      endcase
      while (items_sent < 25 + (ph + 1) * PHASE_ITEMS) gen_random_line();
      cmd_if.valid <= 1'b0;
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d requests in four idling phases: %0d results checked, %0d lines decoded",
             items_sent, result_count, line_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
design/scli_pkg.sv
design/scli_in_if.sv
design/scli_out_if.sv
design/scli_ram.sv
design/serial_command_line_interpreter.sv
test/scli_checker.sv
test/tb_serial_command_line_interpreter.sv
